[sv/bkq_pkg.sv]
// ----------------------------------------------------------------------------
// bkq_pkg
// Shared constants, types and encoder functions for the bounded key queue.
// ----------------------------------------------------------------------------
package bkq_pkg;

  localparam int KEY_RANGE  = 16384;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 15;                       // field width, keys 1..KEY_RANGE
  localparam int KIDX_W     = $clog2(KEY_RANGE);        // zero-based key index
  localparam int WORD_BITS  = 64;                       // bitmap leaf word
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int NWORDS     = KEY_RANGE / WORD_BITS;
  localparam int WRD_W      = KIDX_W - BIT_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_LEAF,
    ST_FIND
  } state_t;

  typedef enum logic {
    MODE_ADD = 1'b0,
    MODE_REM = 1'b1
  } mode_t;

  // lowest set bit of a leaf word
  function automatic logic [BIT_W-1:0] leaf_lsb(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // highest set bit of a leaf word
  function automatic logic [BIT_W-1:0] leaf_msb(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // lowest set bit of the summary vector
  function automatic logic [WRD_W-1:0] summ_lsb(input logic [NWORDS-1:0] v);
    logic [WRD_W-1:0] r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WRD_W'(i);
    end
    return r;
  endfunction

  // highest set bit of the summary vector
  function automatic logic [WRD_W-1:0] summ_msb(input logic [NWORDS-1:0] v);
    logic [WRD_W-1:0] r;
    r = '0;
    for (int i = 0; i < NWORDS; i++) begin
      if (v[i]) r = WRD_W'(i);
    end
    return r;
  endfunction

endpackage

[sv/bkq_if.sv]
// ----------------------------------------------------------------------------
// bkq_if
// Valid/ready channel interfaces: input items, results and configuration.
// ----------------------------------------------------------------------------
interface bkq_in_if
  import bkq_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;
  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

interface bkq_out_if
  import bkq_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] removed_key;
  logic             queue_was_empty;
  modport source (output valid, removed_key, queue_was_empty, input ready);
  modport sink   (input valid, removed_key, queue_was_empty, output ready);
endinterface

interface bkq_cfg_if;
  logic valid;
  logic ready;
  logic remove_from_max;
  modport source (output valid, remove_from_max, input ready);
  modport sink   (input valid, remove_from_max, output ready);
endinterface

[sv/bkq_ram.sv]
// ----------------------------------------------------------------------------
// bkq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bkq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[sv/bounded_key_min_max_queue.sv]
// ----------------------------------------------------------------------------
// bounded_key_min_max_queue
// Double-ended priority queue over keys 1..KEY_RANGE with saturating counts.
// ----------------------------------------------------------------------------
// User notes: one occupancy count per key sits in a RAM, and a two-level
// occupancy bitmap (a RAM of 64-bit leaf words plus a 256-bit summary in
// flops) finds the next occupied key after the last entry of a bound key is
// taken. An add beat produces no result; a remove beat produces one result.
// After reset the block runs a clearing pass over all KEY_RANGE (16384)
// entries of the count RAM (the leaf RAM is cleared in the same pass) and
// takes no input beat until it ends; config writes are taken at any time.
// An add reads the count, then writes it back. A remove adds a leaf read and
// encode when the new bound lies in another leaf word. An add with an
// out-of-range key is dropped on accept. The next beat is accepted while a
// result still waits in the output register; a remove then stalls in its
// update cycle until that result is taken.
module bounded_key_min_max_queue
  import bkq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bkq_in_if.sink            in_ch,
  bkq_out_if.source         out_ch,
  bkq_cfg_if.sink           cfg_ch
);

  // control state
  state_t               state_r, state_nxt;
  logic                 clr_busy_r;
  logic [KIDX_W-1:0]    clr_addr_r;
  logic                 pol_r;
  logic                 hold_r, hold_nxt;
  logic [KEY_W-1:0]     lo_r, lo_nxt;
  logic [KEY_W-1:0]     hi_r, hi_nxt;
  logic [NWORDS-1:0]    summ_r, summ_nxt;
  logic                 out_valid_r, out_valid_nxt;
  // payload
  logic                 mode_r;
  logic [KEY_W-1:0]     key_r;      // key of the add, or the taken key
  logic [KIDX_W-1:0]    tgt_r;
  logic [WRD_W-1:0]     srch_w_r, srch_w_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;
  logic                 out_empty_r, out_empty_nxt;

  // memory ports
  logic                  cnt_we, leaf_we, leaf_re;
  logic [KIDX_W-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
  logic [WRD_W-1:0]      leaf_waddr, leaf_raddr;
  logic [WORD_BITS-1:0]  leaf_wdata, leaf_rd;

  logic                  in_acc, in_rdy, key_bad, out_free;
  logic [KEY_W-1:0]      sel_key;
  logic [KIDX_W-1:0]     sel_idx;
  logic [WRD_W-1:0]      tw;
  logic [BIT_W-1:0]      tb;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [WORD_BITS-1:0]  leaf_clr, leaf_up, leaf_dn;
  logic [NWORDS-1:0]     summ_up, summ_dn;

  assign in_rdy       = (state_r == ST_IDLE) && !clr_busy_r;
  assign in_ch.ready  = in_rdy;
  assign in_acc       = in_ch.valid && in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // key above range: bit 14 set with any lower bit, or zero
  assign key_bad = (in_ch.key == '0) || (in_ch.key > KEY_W'(KEY_RANGE));
  assign sel_key = (in_ch.mode == MODE_ADD) ? in_ch.key : (pol_r ? hi_r : lo_r);
  assign sel_idx = KIDX_W'(sel_key - KEY_W'(1));

  assign tw = tgt_r[KIDX_W-1:BIT_W];
  assign tb = tgt_r[BIT_W-1:0];

  assign cnt_dec  = cnt_rd - COUNT_BITS'(cnt_rd != '0);
  assign leaf_clr = leaf_rd & ~(WORD_BITS'(1) << tb);
  // leaf bits strictly above / below the taken bit
  assign leaf_up  = leaf_clr & (({WORD_BITS{1'b1}} << tb) << 1);
  assign leaf_dn  = leaf_clr & ~({WORD_BITS{1'b1}} << tb);
  assign summ_up  = summ_r & (({NWORDS{1'b1}} << tw) << 1);
  assign summ_dn  = summ_r & ~({NWORDS{1'b1}} << tw);

  // count RAM: one write per cycle, read on accept
  bkq_ram #(.WIDTH(COUNT_BITS), .DEPTH(KEY_RANGE)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_acc),
    .raddr (sel_idx),
    .rdata (cnt_rd)
  );

  // leaf bitmap RAM
  bkq_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_raddr),
    .rdata (leaf_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      pol_r       <= 1'b0;
      hold_r      <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      summ_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_r      <= hold_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      summ_r      <= summ_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + KIDX_W'(1);
        if (clr_addr_r == '1) clr_busy_r <= 1'b0;
      end
      if (cfg_ch.valid) pol_r <= cfg_ch.remove_from_max;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_ch.mode;
      key_r  <= sel_key;
      tgt_r  <= sel_idx;
    end
    srch_w_r    <= srch_w_nxt;
    out_key_r   <= out_key_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    summ_nxt      = summ_r;
    srch_w_nxt    = srch_w_r;
    out_key_nxt   = out_key_r;
    out_empty_nxt = out_empty_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cnt_we        = 1'b0;
    cnt_waddr     = tgt_r;
    cnt_wdata     = cnt_rd;
    leaf_we       = 1'b0;
    leaf_waddr    = tw;
    leaf_wdata    = leaf_rd;
    leaf_re       = in_acc;
    leaf_raddr    = sel_idx[KIDX_W-1:BIT_W];

    if (clr_busy_r) begin
      cnt_we     = 1'b1;
      cnt_waddr  = clr_addr_r;
      cnt_wdata  = '0;
      leaf_we    = (clr_addr_r[KIDX_W-1:WRD_W] == '0);
      leaf_waddr = clr_addr_r[WRD_W-1:0];
      leaf_wdata = '0;
    end

    case (state_r)
      ST_IDLE: begin
        // out-of-range add is dropped right here
        if (in_acc && !(in_ch.mode == MODE_ADD && key_bad)) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (mode_r == MODE_ADD) begin
          state_nxt = ST_IDLE;
          if (cnt_rd != COUNT_MAX) begin
            cnt_we       = 1'b1;
            cnt_wdata    = cnt_rd + COUNT_BITS'(1);
            leaf_we      = 1'b1;
            leaf_wdata   = leaf_rd | (WORD_BITS'(1) << tb);
            summ_nxt[tw] = 1'b1;
            hold_nxt     = 1'b1;
            if (!hold_r || key_r < lo_r) lo_nxt = key_r;
            if (!hold_r || key_r > hi_r) hi_nxt = key_r;
          end
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_empty_nxt = !hold_r;
          out_key_nxt   = hold_r ? key_r : '0;
          if (hold_r) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_dec;
            if (cnt_dec == '0) begin
              leaf_we    = 1'b1;
              leaf_wdata = leaf_clr;
              if (leaf_clr == '0) summ_nxt[tw] = 1'b0;
              if (lo_r >= hi_r) begin
                hold_nxt = 1'b0;
                lo_nxt   = '0;
                hi_nxt   = '0;
              end else if (!pol_r) begin
                if (leaf_up != '0) begin
                  lo_nxt = KEY_W'({tw, leaf_lsb(leaf_up)}) + KEY_W'(1);
                end else begin
                  srch_w_nxt = summ_lsb(summ_up);
                  state_nxt  = ST_LEAF;
                end
              end else begin
                if (leaf_dn != '0) begin
                  hi_nxt = KEY_W'({tw, leaf_msb(leaf_dn)}) + KEY_W'(1);
                end else begin
                  srch_w_nxt = summ_msb(summ_dn);
                  state_nxt  = ST_LEAF;
                end
              end
            end
          end
        end
      end
      ST_LEAF: begin
        // leaf write of the update cycle is already in; different word anyway
        leaf_re    = 1'b1;
        leaf_raddr = srch_w_r;
        state_nxt  = ST_FIND;
      end
      ST_FIND: begin
        state_nxt = ST_IDLE;
        if (!pol_r) lo_nxt = KEY_W'({srch_w_r, leaf_lsb(leaf_rd)}) + KEY_W'(1);
        else        hi_nxt = KEY_W'({srch_w_r, leaf_msb(leaf_rd)}) + KEY_W'(1);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.removed_key     = out_key_r;
  assign out_ch.queue_was_empty = out_empty_r;

  // bounds are consistent with the held flag
  a_bounds_held: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> (lo_r != '0 && lo_r <= hi_r))
    else $error("bounds out of order while entries held");

  a_bounds_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_r |-> (lo_r == '0 && hi_r == '0))
    else $error("bounds not cleared while empty");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_rdy)
    else $error("input taken during clearing pass");

  a_leaf_find: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LEAF |=> state_r == ST_FIND)
    else $error("leaf search did not complete");

  a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_key_r == '0)
    else $error("empty result carries a key");

endmodule
